// ===== rtl/vpi_pkg.sv =====
// Shared types, constants and the saturation helper of the Verlet point integrator.
package vpi_pkg;

  // Fraction bits of the signed position, force and acceleration format.
  localparam int unsigned FracBits = 16;

  localparam int unsigned DataW  = 32;
  localparam int unsigned GravW  = 31;
  localparam int unsigned ProdW  = 66;
  localparam int unsigned AxisN  = 3;
  localparam int unsigned AxisY  = 1;

  // Reset values of the configuration registers.
  localparam logic [DataW-1:0] InvMassReset = DataW'(64'd1 << FracBits);
  localparam logic [DataW-1:0] DtSqReset    = 32'd1193046;
  localparam logic [GravW-1:0] GravReset    = GravW'((64'd642908 << FracBits) >> 16);

  // Item operation codes.
  typedef enum logic [1:0] {
    OpForce  = 2'd0,
    OpTick   = 2'd1,
    OpSetPos = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgInvMass = 2'd0,
    CfgDtSq    = 2'd1,
    CfgGrav    = 2'd2,
    CfgGravEn  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              clip;
    logic signed [31:0] value;
  } sat_t;

  // Per-axis next state computed for one item.
  typedef struct packed {
    logic signed [31:0] cur;
    logic signed [31:0] prior;
    logic signed [31:0] acc;
    logic               clip;
  } axis_res_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic sat_t sat32(input logic signed [ProdW-1:0] v);
    sat_t r;
    if (v[ProdW-1:31] == '0 || v[ProdW-1:31] == '1) begin
      r.clip  = 1'b0;
      r.value = v[31:0];
    end else begin
      r.clip  = 1'b1;
      r.value = v[ProdW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== rtl/vpi_in_if.sv =====
// Input item channel of the Verlet point integrator.
interface vpi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] vector_x;
  logic signed [31:0] vector_y;
  logic signed [31:0] vector_z;

  modport source (output valid, operation, vector_x, vector_y, vector_z, input ready);
  modport sink   (input valid, operation, vector_x, vector_y, vector_z, output ready);
endinterface

// ===== rtl/vpi_out_if.sv =====
// Result item channel of the Verlet point integrator.
interface vpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               saturated;

  modport source (output valid, pos_x, pos_y, pos_z, saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, saturated, output ready);
endinterface

// ===== rtl/vpi_axis.sv =====
// One axis of the integrator: force accumulate, Verlet step and position load.
module vpi_axis (
  input  logic [1:0]          op_i,
  input  logic signed [31:0]  vec_i,
  input  logic signed [31:0]  cur_i,
  input  logic signed [31:0]  prior_i,
  input  logic signed [31:0]  acc_i,
  input  logic [31:0]         inv_mass_i,
  input  logic [31:0]         dt_sq_i,
  input  logic [30:0]         grav_sub_i,
  output vpi_pkg::axis_res_t  res_o
);

  logic signed [vpi_pkg::ProdW-1:0] acc_w;
  logic signed [vpi_pkg::ProdW-1:0] acc_g;
  vpi_pkg::sat_t                    acc_eff;
  logic signed [32:0]               mul_a;
  logic signed [32:0]               mul_b;
  logic signed [vpi_pkg::ProdW-1:0] prod;
  logic signed [vpi_pkg::ProdW-1:0] sum_f;
  logic signed [vpi_pkg::ProdW-1:0] next_p;
  vpi_pkg::sat_t                    sat_f;
  vpi_pkg::sat_t                    sat_n;
  logic                             is_force;

  assign is_force = (vpi_pkg::op_e'(op_i) == vpi_pkg::OpForce);

  // Gravity applies to the accumulator ahead of the tick multiply.
  assign acc_w   = {{34{acc_i[31]}}, acc_i};
  assign acc_g   = acc_w - {35'd0, grav_sub_i};
  assign acc_eff = vpi_pkg::sat32(acc_g);

  // Share one multiplier between force scaling and the dt^2 term.
  assign mul_a = is_force ? {vec_i[31], vec_i} : {acc_eff.value[31], acc_eff.value};
  assign mul_b = is_force ? {1'b0, inv_mass_i} : {1'b0, dt_sq_i};
  assign prod  = mul_a * mul_b;

  // Keep the whole expression signed so the product shifts as a floor.
  assign sum_f  = (prod >>> vpi_pkg::FracBits) + acc_w;
  assign next_p = ($signed({{34{cur_i[31]}}, cur_i}) <<< 1)
                  - $signed({{34{prior_i[31]}}, prior_i})
                  + (prod >>> 32);
  assign sat_f  = vpi_pkg::sat32(sum_f);
  assign sat_n  = vpi_pkg::sat32(next_p);

  always_comb begin
    res_o.cur   = cur_i;
    res_o.prior = prior_i;
    res_o.acc   = acc_i;
    res_o.clip  = 1'b0;
    case (vpi_pkg::op_e'(op_i))
      vpi_pkg::OpForce: begin
        res_o.acc  = sat_f.value;
        res_o.clip = sat_f.clip;
      end
      vpi_pkg::OpTick: begin
        res_o.prior = cur_i;
        res_o.cur   = sat_n.value;
        res_o.acc   = '0;
        res_o.clip  = acc_eff.clip | sat_n.clip;
      end
      vpi_pkg::OpSetPos: begin
        res_o.cur = vec_i;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/verlet_point_integrator_unit.sv =====
// Top level of the three-axis Verlet point integrator.
// An accepted item moves from the input register into the result register once that slot is free.
// Throughput: one item per cycle unless out_o.ready stalls; the three axis
// multipliers between the input and result registers set the cycle path.
// Reset: positions and the accumulator clear to zero, the pipeline empties,
// and the configuration registers take their default values.
module verlet_point_integrator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  vpi_in_if.sink           in_i,
  vpi_out_if.source        out_o
);

  // Configuration registers.
  logic [31:0] inv_mass_q;
  logic [31:0] dt_sq_q;
  logic [30:0] grav_q;
  logic        grav_en_q;

  // Input register stage.
  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  logic signed [31:0] s1_vec_q [vpi_pkg::AxisN];

  // Body state.
  logic signed [31:0] cur_q   [vpi_pkg::AxisN];
  logic signed [31:0] prior_q [vpi_pkg::AxisN];
  logic signed [31:0] acc_q   [vpi_pkg::AxisN];

  // Result register.
  logic               out_valid_q;
  logic signed [31:0] out_pos_q [vpi_pkg::AxisN];
  logic               out_sat_q;

  vpi_pkg::axis_res_t res [vpi_pkg::AxisN];
  logic               advance;
  logic               in_fire;

  // Move the staged item into the result register whenever the result slot
  // is free or is being emptied this cycle; take a new item whenever the
  // input stage is empty or advances.
  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q <= vpi_pkg::InvMassReset;
      dt_sq_q    <= vpi_pkg::DtSqReset;
      grav_q     <= vpi_pkg::GravReset;
      grav_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (vpi_pkg::cfg_idx_e'(cfg_idx_i))
        vpi_pkg::CfgInvMass: inv_mass_q <= cfg_data_i;
        vpi_pkg::CfgDtSq:    dt_sq_q    <= cfg_data_i;
        vpi_pkg::CfgGrav:    grav_q     <= cfg_data_i[30:0];
        vpi_pkg::CfgGravEn:  grav_en_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= in_i.operation;
      s1_vec_q[0] <= in_i.vector_x;
      s1_vec_q[1] <= in_i.vector_y;
      s1_vec_q[2] <= in_i.vector_z;
    end
  end

  // One datapath per axis; only y sees gravity, and only when enabled.
  for (genvar g = 0; g < vpi_pkg::AxisN; g++) begin : g_axis
    logic [30:0] grav_sub;
    assign grav_sub = (g == vpi_pkg::AxisY && grav_en_q) ? grav_q : '0;

    vpi_axis u_axis (
      .op_i       (s1_op_q),
      .vec_i      (s1_vec_q[g]),
      .cur_i      (cur_q[g]),
      .prior_i    (prior_q[g]),
      .acc_i      (acc_q[g]),
      .inv_mass_i (inv_mass_q),
      .dt_sq_i    (dt_sq_q),
      .grav_sub_i (grav_sub),
      .res_o      (res[g])
    );
  end

  // Commit state as the item moves into the result register, so the next
  // staged item already sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vpi_pkg::AxisN; i++) begin
        cur_q[i]   <= '0;
        prior_q[i] <= '0;
        acc_q[i]   <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < vpi_pkg::AxisN; i++) begin
        cur_q[i]   <= res[i].cur;
        prior_q[i] <= res[i].prior;
        acc_q[i]   <= res[i].acc;
      end
    end
  end

  // Load the result payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < vpi_pkg::AxisN; i++) begin
        out_pos_q[i] <= res[i].cur;
      end
      out_sat_q <= res[0].clip | res[1].clip | res[2].clip;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pos_x     = out_pos_q[0];
  assign out_o.pos_y     = out_pos_q[1];
  assign out_o.pos_z     = out_pos_q[2];
  assign out_o.saturated = out_sat_q;

endmodule

// ===== dv/vpi_checker.sv =====
`timescale 1ns / 100ps
// Position predictor and result comparator for the Verlet point integrator.
module vpi_checker
  import vpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  vpi_in_if           in_i,
  vpi_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic signed [63:0] WideMax = 64'sd2147483647;
  localparam logic signed [63:0] WideMin = -64'sd2147483648;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } clamp_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               saturated;
  } point_t;

  // Predictor copy of the configuration and the body state.
  logic [31:0]        inv_mass;
  logic [31:0]        dt_sq;
  logic [GravW-1:0]   grav;
  logic               grav_en;
  logic signed [31:0] cur_pos  [AxisN];
  logic signed [31:0] prev_pos [AxisN];
  logic signed [31:0] accel    [AxisN];

  point_t      position_q [$];
  int unsigned failures = 0;
  int unsigned pending  = 0;

  assign fail_count_o = failures;
  assign pending_o    = pending;

  function automatic clamp_t clamp32(input logic signed [63:0] v);
    clamp_t r;
    r.clip = (v > WideMax) || (v < WideMin);
    if (r.clip) begin
      r.val = v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Advance the body by one item and queue the position it reports.
  task automatic integrate_item(input logic [1:0] op, input logic signed [31:0] x,
                                input logic signed [31:0] y, input logic signed [31:0] z);
    logic signed [31:0] vec [AxisN];
    logic signed [63:0] wide;
    clamp_t             c;
    point_t             p;
    logic               clip;
    vec  = '{x, y, z};
    clip = 1'b0;
    case (op)
      OpForce: begin
        for (int a = 0; a < AxisN; a++) begin
          wide = 64'(vec[a]) * $signed({32'd0, inv_mass});
          wide = (wide >>> FracBits) + 64'(accel[a]);
          c = clamp32(wide);
          accel[a] = c.val;
          clip |= c.clip;
        end
      end
      OpTick: begin
        if (grav_en) begin
          c = clamp32(64'(accel[AxisY]) - $signed({33'd0, grav}));
          accel[AxisY] = c.val;
          clip |= c.clip;
        end
        for (int a = 0; a < AxisN; a++) begin
          wide = 64'(accel[a]) * $signed({32'd0, dt_sq});
          wide = (wide >>> 32) + (64'(cur_pos[a]) <<< 1) - 64'(prev_pos[a]);
          prev_pos[a] = cur_pos[a];
          c = clamp32(wide);
          cur_pos[a] = c.val;
          clip |= c.clip;
          accel[a] = '0;
        end
      end
      OpSetPos: begin
        for (int a = 0; a < AxisN; a++) cur_pos[a] = vec[a];
      end
      default: ;
    endcase
    p.pos_x     = cur_pos[0];
    p.pos_y     = cur_pos[1];
    p.pos_z     = cur_pos[2];
    p.saturated = clip;
    position_q.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    point_t want;
    if (!rst_ni) begin
      inv_mass = InvMassReset;
      dt_sq    = DtSqReset;
      grav     = GravReset;
      grav_en  = 1'b1;
      for (int a = 0; a < AxisN; a++) begin
        cur_pos[a]  = '0;
        prev_pos[a] = '0;
        accel[a]    = '0;
      end
      position_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgInvMass: inv_mass = cfg_data_i;
          CfgDtSq:    dt_sq    = cfg_data_i;
          CfgGrav:    grav     = cfg_data_i[GravW-1:0];
          CfgGravEn:  grav_en  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        integrate_item(in_i.operation, in_i.vector_x, in_i.vector_y, in_i.vector_z);
      end
      if (out_i.valid && out_i.ready) begin
        if (position_q.size() == 0) begin
          $error("result with no item pending: pos (%0d, %0d, %0d) saturated %0b",
                 out_i.pos_x, out_i.pos_y, out_i.pos_z, out_i.saturated);
          failures++;
        end else begin
          want = position_q.pop_front();
          if (out_i.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, out_i.pos_x);
            failures++;
          end
          if (out_i.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, out_i.pos_y);
            failures++;
          end
          if (out_i.pos_z !== want.pos_z) begin
            $error("pos_z: expected %0d, got %0d", want.pos_z, out_i.pos_z);
            failures++;
          end
          if (out_i.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_i.saturated);
            failures++;
          end
        end
      end
    end
    pending = position_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the integrator testbench: clock, reset, stimulus, idling and verdict.
module testbench;
  import vpi_pkg::*;

  // Operation code the block must treat as a no-op.
  localparam logic [1:0]        OpUnused    = 2'd3;
  localparam int unsigned       StallLimit  = 2000;
  localparam int unsigned       PhaseItems  = 130;
  localparam int unsigned       PhaseCount  = 6;
  localparam int unsigned       DrainCycles = 6;
  localparam logic signed [31:0] PosMax     = 32'sh7fff_ffff;
  localparam logic signed [31:0] PosMin     = 32'sh8000_0000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  // Idling is on for most phases; the final phase runs at full rate.
  bit          idle_on = 1'b1;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  vpi_in_if  item_ch ();
  vpi_out_if result_ch ();

  verlet_point_integrator_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (item_ch),
    .out_o      (result_ch)
  );

  vpi_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_i         (item_ch),
    .out_i        (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side in random bursts while idling is on.
  initial begin : result_ready
    int unsigned stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(16, 1);
      end
      if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** verlet_point_integrator_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Small and moderate values, the two extremes and full-width noise, with
  // the noise as likely as the small and moderate values together.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0:       return PosMax;
      1:       return PosMin;
      2:       return 32'(int'($urandom_range(512)) - 256);
      3, 4:    return 32'(int'($urandom_range(2097152)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  // Present one item at the falling edge and hold it until it is taken.
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z);
    int unsigned gap;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(16, 1);
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.vector_x  <= x;
    item_ch.vector_y  <= y;
    item_ch.vector_z  <= z;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  // Drain the pipeline, then write all four registers back to back.
  task automatic load_settings(input logic [31:0] inv, input logic [31:0] dt,
                               input logic [31:0] grav, input logic [31:0] en);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgInvMass;
    cfg_data <= inv;
    @(negedge clk);
    cfg_idx  <= CfgDtSq;
    cfg_data <= dt;
    @(negedge clk);
    cfg_idx  <= CfgGrav;
    cfg_data <= grav;
    @(negedge clk);
    cfg_idx  <= CfgGravEn;
    cfg_data <= en;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] inv, dt, grav;
    int unsigned pick;
    logic [1:0]  op;

    // Hold every input at a known value under reset, then release it.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CfgInvMass;
    cfg_data           = '0;
    item_ch.valid      = 1'b0;
    item_ch.operation  = OpForce;
    item_ch.vector_x   = '0;
    item_ch.vector_y   = '0;
    item_ch.vector_z   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default settings: tick from rest, the unused code, then drive the
    // accumulator and positions into both rails.
    send_item(OpTick, 0, 0, 0);
    send_item(OpUnused, PosMax, PosMin, -1);
    send_item(OpSetPos, PosMax, PosMin, 0);
    send_item(OpForce, PosMax, PosMin, 1);
    send_item(OpForce, PosMax, PosMin, -1);   // accumulator clips on x and y
    send_item(OpTick, 0, 0, 0);               // gravity and next position clip
    send_item(OpTick, 0, 0, 0);
    send_item(OpSetPos, PosMin, PosMax, -1);
    send_item(OpTick, 0, 0, 0);
    send_item(OpSetPos, 0, 0, 0);

    // Largest mass, step and gravity.
    load_settings(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'd1);
    send_item(OpForce, 1, -1, 32'sh0001_0000);
    send_item(OpTick, 0, 0, 0);
    send_item(OpForce, PosMin, PosMax, 0);
    send_item(OpTick, 0, 0, 0);
    send_item(OpTick, 0, 0, 0);

    // All registers zero: forces and gravity must have no effect.
    load_settings(32'd0, 32'd0, 32'd0, 32'd0);
    send_item(OpForce, PosMax, PosMax, PosMax);
    send_item(OpTick, 0, 0, 0);
    send_item(OpSetPos, -1, 1, PosMin);
    send_item(OpTick, 0, 0, 0);
    send_item(OpUnused, 0, 0, 0);

    // Random phases, each with fresh settings; full-width writes also check
    // that the narrow registers drop their upper bits.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case ($urandom_range(3))
        0:       inv = '0;
        1:       inv = 32'hffff_ffff;
        2:       inv = InvMassReset;
        default: inv = $urandom_range(1 << 20);
      endcase
      case ($urandom_range(3))
        0:       dt = '0;
        1:       dt = 32'hffff_ffff;
        2:       dt = DtSqReset;
        default: dt = $urandom;
      endcase
      case ($urandom_range(3))
        0:       grav = '0;
        1:       grav = 32'hffff_ffff;
        2:       grav = {1'b1, GravReset};
        default: grav = $urandom;
      endcase
      load_settings(inv, dt, grav, $urandom);
      idle_on = (ph != PhaseCount - 1) && ($urandom_range(3) != 0);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        if (pick < 40)      op = OpForce;
        else if (pick < 75) op = OpTick;
        else if (pick < 95) op = OpSetPos;
        else                op = OpUnused;
        send_item(op, pick_value(), pick_value(), pick_value());
      end
    end

    // Drop valid, wait for the last results, then let the pipeline settle.
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("** verlet_point_integrator_unit: PASSED **");
    end else begin
      $display("** verlet_point_integrator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vpi_pkg.sv
rtl/vpi_in_if.sv
rtl/vpi_out_if.sv
rtl/vpi_axis.sv
rtl/verlet_point_integrator_unit.sv
dv/vpi_checker.sv
dv/testbench.sv
